FILE: hw/rtl/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg: shared types and constants of the GPIO port register block
// Register kinds, address maps of both layouts, config bundle, offset decoder.
// ----------------------------------------------------------------------------
package gpr_pkg;

	localparam int unsigned PIN_COUNT = 32;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned OFF_W     = 5;
	localparam int unsigned PADDR_W   = 3;

	localparam logic [DATA_W-1:0] PIN_LIMIT =
		DATA_W'((64'd1 << PIN_COUNT) - 64'd1);

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic LAYOUT_A = 1'b0;
	localparam logic LAYOUT_B = 1'b1;

	// config register index, taken from paddr[2]
	localparam logic CFG_LAYOUT   = 1'b0;
	localparam logic CFG_PIN_MASK = 1'b1;

	// layout A word offsets
	localparam logic [OFF_W-1:0] A_IN  = 5'd8;
	localparam logic [OFF_W-1:0] A_OUT = 5'd9;
	localparam logic [OFF_W-1:0] A_DIR = 5'd10;
	localparam logic [OFF_W-1:0] A_CLR = 5'd11;
	localparam logic [OFF_W-1:0] A_SET = 5'd12;
	localparam logic [OFF_W-1:0] A_PEN = 5'd16;
	localparam logic [OFF_W-1:0] A_PTY = 5'd17;

	// layout B word offsets
	localparam logic [OFF_W-1:0] B_IN  = 5'd0;
	localparam logic [OFF_W-1:0] B_OUT = 5'd4;
	localparam logic [OFF_W-1:0] B_SET = 5'd5;
	localparam logic [OFF_W-1:0] B_CLR = 5'd6;
	localparam logic [OFF_W-1:0] B_TGL = 5'd7;
	localparam logic [OFF_W-1:0] B_DIR = 5'd8;
	localparam logic [OFF_W-1:0] B_PEN = 5'd24;
	localparam logic [OFF_W-1:0] B_PTY = 5'd28;

	typedef enum logic [3:0] {
		REG_NONE,
		REG_IN,
		REG_OUT,
		REG_DIR,
		REG_SET,
		REG_CLR,
		REG_TGL,
		REG_PEN,
		REG_PTY
	} reg_kind_t;

	typedef struct packed {
		logic              layout;
		logic [DATA_W-1:0] live_mask;
	} cfg_t;

	function automatic reg_kind_t gpr_decode(input logic layout, input logic [OFF_W-1:0] off);
		reg_kind_t kind;
		kind = REG_NONE;
		if (layout == LAYOUT_A) begin
			unique case (off)
				A_IN:    kind = REG_IN;
				A_OUT:   kind = REG_OUT;
				A_DIR:   kind = REG_DIR;
				A_CLR:   kind = REG_CLR;
				A_SET:   kind = REG_SET;
				A_PEN:   kind = REG_PEN;
				A_PTY:   kind = REG_PTY;
				default: kind = REG_NONE;
			endcase
		end else begin
			unique case (off)
				B_IN:    kind = REG_IN;
				B_OUT:   kind = REG_OUT;
				B_SET:   kind = REG_SET;
				B_CLR:   kind = REG_CLR;
				B_TGL:   kind = REG_TGL;
				B_DIR:   kind = REG_DIR;
				B_PEN:   kind = REG_PEN;
				B_PTY:   kind = REG_PTY;
				default: kind = REG_NONE;
			endcase
		end
		return kind;
	endfunction

endpackage

FILE: hw/rtl/gpr_req_if.sv
// ----------------------------------------------------------------------------
// gpr_req_if: request channel of the GPIO port register block
// Valid/ready handshake carrying one bus access and the sampled pad levels.
// ----------------------------------------------------------------------------
interface gpr_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [4:0]  word_offset;
	logic [31:0] write_data;
	logic [31:0] pin_levels;

	modport source (output valid, cmd, word_offset, write_data, pin_levels, input ready);
	modport sink   (input valid, cmd, word_offset, write_data, pin_levels, output ready);
endinterface

FILE: hw/rtl/gpr_rsp_if.sv
// ----------------------------------------------------------------------------
// gpr_rsp_if: result channel of the GPIO port register block
// Valid/ready handshake carrying read data, pad controls and offset flag.
// ----------------------------------------------------------------------------
interface gpr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic [31:0] out_level;
	logic [31:0] out_enable;
	logic [31:0] pull_on;
	logic [31:0] pull_up_sel;
	logic        bad_offset;

	modport source (output valid, read_data, out_level, out_enable, pull_on, pull_up_sel,
		bad_offset, input ready);
	modport sink   (input valid, read_data, out_level, out_enable, pull_on, pull_up_sel,
		bad_offset, output ready);
endinterface

FILE: hw/rtl/gpr_cfg.sv
// ----------------------------------------------------------------------------
// gpr_cfg: APB configuration registers
// Holds layout select and pin mask; derives the live pin mask.
// ----------------------------------------------------------------------------
module gpr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gpr_pkg::PADDR_W-1:0]   paddr,
	input  logic [gpr_pkg::DATA_W-1:0]    pwdata,
	output logic [gpr_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output gpr_pkg::cfg_t                 cfg
);
	import gpr_pkg::*;

	logic              layout_q;
	logic [DATA_W-1:0] pin_mask_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q   <= LAYOUT_A;
			pin_mask_q <= '1;
		end else if (wr_en) begin
			unique case (paddr[2])
				CFG_LAYOUT:   layout_q   <= pwdata[0];
				CFG_PIN_MASK: pin_mask_q <= pwdata;
				default:      ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			CFG_LAYOUT:   prdata = {{(DATA_W-1){1'b0}}, layout_q};
			CFG_PIN_MASK: prdata = pin_mask_q;
			default:      prdata = '0;
		endcase
	end

	assign cfg.layout    = layout_q;
	assign cfg.live_mask = pin_mask_q & PIN_LIMIT;

endmodule

FILE: hw/rtl/gpr_core.sv
// ----------------------------------------------------------------------------
// gpr_core: access pipeline and pin registers
// Input stage, decode and masked update, result stage; state updates on move.
// ----------------------------------------------------------------------------
module gpr_core (
	input  logic          clk,
	input  logic          arst_n,
	input  gpr_pkg::cfg_t cfg,
	gpr_req_if.sink       req,
	gpr_rsp_if.source     rsp
);
	import gpr_pkg::*;

	logic              valid_s1;
	logic              cmd_s1;
	logic [OFF_W-1:0]  off_s1;
	logic [DATA_W-1:0] wdata_s1;
	logic [DATA_W-1:0] pins_s1;

	logic              valid_s2;
	logic [DATA_W-1:0] rdata_s2;
	logic              bad_s2;

	logic [DATA_W-1:0] latch_q;
	logic [DATA_W-1:0] dir_q;
	logic [DATA_W-1:0] pen_q;
	logic [DATA_W-1:0] pty_q;

	logic [DATA_W-1:0] latch_d;
	logic [DATA_W-1:0] dir_d;
	logic [DATA_W-1:0] pen_d;
	logic [DATA_W-1:0] pty_d;
	logic [DATA_W-1:0] rdata_d;
	logic [DATA_W-1:0] m;
	logic [DATA_W-1:0] wm;
	reg_kind_t         kind;
	logic              adv_s2;
	logic              adv_s1;

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = valid_s1 && adv_s2;
	assign req.ready = !valid_s1 || adv_s2;

	assign m    = cfg.live_mask;
	assign wm   = wdata_s1 & m;
	assign kind = gpr_decode(cfg.layout, off_s1);

	always_comb begin
		latch_d = latch_q;
		dir_d   = dir_q;
		pen_d   = pen_q;
		pty_d   = pty_q;
		rdata_d = '0;
		if (cmd_s1 == CMD_WRITE) begin
			case (kind)
				REG_OUT: latch_d = (latch_q & ~m) | wm;
				REG_DIR: dir_d   = (dir_q & ~m) | wm;
				REG_SET: latch_d = latch_q | wm;
				REG_CLR: latch_d = latch_q & ~wm;
				REG_TGL: latch_d = latch_q ^ wm;
				REG_PEN: pen_d   = (pen_q & ~m) | wm;
				REG_PTY: pty_d   = (pty_q & ~m) | wm;
				default: ;
			endcase
		end else begin
			case (kind)
				REG_IN:  rdata_d = pins_s1 & m;
				REG_OUT: rdata_d = latch_q;
				REG_DIR: rdata_d = dir_q;
				REG_PEN: rdata_d = pen_q;
				REG_PTY: rdata_d = pty_q;
				default: rdata_d = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			latch_q  <= '0;
			dir_q    <= '0;
			pen_q    <= '0;
			pty_q    <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				latch_q <= latch_d;
				dir_q   <= dir_d;
				pen_q   <= pen_d;
				pty_q   <= pty_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1   <= req.cmd;
			off_s1   <= req.word_offset;
			wdata_s1 <= req.write_data;
			pins_s1  <= req.pin_levels;
		end
		if (adv_s1) begin
			rdata_s2 <= rdata_d;
			bad_s2   <= (kind == REG_NONE);
		end
	end

	// pad controls follow state and config; state only moves as the result stage reloads
	assign rsp.valid       = valid_s2;
	assign rsp.read_data   = rdata_s2;
	assign rsp.bad_offset  = bad_s2;
	assign rsp.out_level   = latch_q;
	assign rsp.out_enable  = (cfg.layout == LAYOUT_A) ? (dir_q & m) : (~dir_q & m);
	assign rsp.pull_on     = pen_q;
	assign rsp.pull_up_sel = pty_q;

`ifndef SYNTHESIS
	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && cmd_s1 == CMD_WRITE) |=> (rsp.read_data == '0))
		else $error("write produced nonzero read data");

	a_bad_offset_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && kind == REG_NONE) |=> ($stable(latch_q) && $stable(dir_q)
		&& $stable(pen_q) && $stable(pty_q)))
		else $error("unmapped access changed state");

	a_stalled_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> valid_s1)
		else $error("stalled request dropped");

	a_ready_low_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && valid_s2))
		else $error("request stalled with free stage");
`endif

endmodule

FILE: hw/rtl/gpio_port_register_block.sv
// ----------------------------------------------------------------------------
// gpio_port_register_block: 32-pin GPIO register block
// A request is held in the input stage, then offered from the result stage.
// Throughput: one request per cycle unless a result stalls; stages decouple.
// A stalled result holds the input stage only once that stage is full.
// Reset: pin registers cleared, layout A, pin mask all ones; no clearing pass.
// ----------------------------------------------------------------------------
module gpio_port_register_block (
	input  logic                          clk,
	input  logic                          arst_n,
	gpr_req_if.sink                       req,
	gpr_rsp_if.source                     rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gpr_pkg::PADDR_W-1:0]   paddr,
	input  logic [gpr_pkg::DATA_W-1:0]    pwdata,
	output logic [gpr_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import gpr_pkg::*;

	cfg_t cfg;

	gpr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gpr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
